FILE: rtl/strd_pkg.sv
package strd_pkg;

  // Widths fixed by the register map and the word formats
  localparam int MAX_DIMS_DEFAULT = 4;
  localparam int DIGIT_W          = 16;
  localparam int ADDR_W           = 32;
  localparam int VALUE_W          = 64;
  localparam int COUNT_W          = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int DIM_COUNT_W      = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_OFFSET   = 3'd0,
    CFG_DIM_COUNT     = 3'd1,
    CFG_SHAPE         = 3'd2,
    CFG_STRIDE        = 3'd3,
    CFG_ELEMENT_COUNT = 3'd4,
    CFG_REDUCE_MODE   = 3'd5,
    CFG_ELEMENT_TYPE  = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_ARGMAX = 3'd0,
    MODE_ARGMIN = 3'd1,
    MODE_MAX    = 3'd2,
    MODE_MIN    = 3'd3,
    MODE_SUM    = 3'd4
  } reduce_mode_t;

  typedef enum logic [1:0] {
    TYPE_INT8  = 2'd0,
    TYPE_INT16 = 2'd1,
    TYPE_INT32 = 2'd2,
    TYPE_INT64 = 2'd3
  } element_type_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_ADDR   = 1'b0,
    KIND_RESULT = 1'b1
  } kind_t;

  // Everything of a result word except the address
  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0]        result_index;
  } strd_fold_t;

  // Sign-extend the low bits of the element width to the full value width
  function automatic logic [VALUE_W-1:0] sext_elem(input logic [VALUE_W-1:0] v,
                                                   input logic [1:0] etype);
    logic [VALUE_W-1:0] r;
    case (etype)
      TYPE_INT8:  r = {{(VALUE_W-8){v[7]}}, v[7:0]};
      TYPE_INT16: r = {{(VALUE_W-16){v[15]}}, v[15:0]};
      TYPE_INT32: r = {{(VALUE_W-32){v[31]}}, v[31:0]};
      default:    r = v;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/strd_in_if.sv
interface strd_in_if;
  import strd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] element_value;

  modport source (output valid, output cmd, output element_value, input ready);
  modport sink   (input valid, input cmd, input element_value, output ready);
endinterface

FILE: rtl/strd_out_if.sv
interface strd_out_if;
  import strd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ADDR_W-1:0]         address;
  logic signed [VALUE_W-1:0] result_value;
  logic [COUNT_W-1:0]        result_index;

  modport source (output valid, output kind, output address, output result_value,
                  output result_index, input ready);
  modport sink   (input valid, input kind, input address, input result_value,
                  input result_index, output ready);
endinterface

FILE: rtl/strd_addr_pipe.sv
module strd_addr_pipe
  import strd_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  strd_fold_t             up_fold,
  input  logic [DIGIT_W-1:0]     up_digits [MAX_DIMS],
  input  logic [ADDR_W-1:0]      base_offset,
  input  logic [CFG_DATA_W-1:0]  stride_packed,
  input  logic [DIM_COUNT_W-1:0] dims_used,
  strd_out_if.source             out_ch
);

  logic               s2_v_r;
  strd_fold_t         s2_fold_r;
  logic [ADDR_W-1:0]  s2_prod_r [MAX_DIMS];
  logic               out_v_r;
  strd_fold_t         out_fold_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               en_out;
  logic               en_s2;
  logic [ADDR_W-1:0]  prod_nxt [MAX_DIMS];
  logic [ADDR_W-1:0]  addr_nxt;

  // Advance each stage when it is empty or the stage after it is moving
  assign en_out   = !out_v_r || out_ch.ready;
  assign en_s2    = !s2_v_r || en_out;
  assign up_ready = en_s2;

  // Per-dimension digit times stride; dimensions out of use add nothing
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < int'(dims_used)) begin
        prod_nxt[d] = ADDR_W'(up_digits[d]) * ADDR_W'(stride_packed[DIGIT_W*d +: DIGIT_W]);
      end else begin
        prod_nxt[d] = '0;
      end
    end
  end

  // Sum base and products, wrap to the address width; result words get a zero address
  always_comb begin
    addr_nxt = base_offset;
    for (int d = 0; d < MAX_DIMS; d++) begin
      addr_nxt = addr_nxt + s2_prod_r[d];
    end
    if (s2_fold_r.kind == KIND_RESULT) begin
      addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_s2) begin
        s2_v_r <= up_valid;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload stages carry no reset
  always_ff @(posedge clk) begin
    if (en_s2 && up_valid) begin
      s2_fold_r <= up_fold;
      s2_prod_r <= prod_nxt;
    end
    if (en_out && s2_v_r) begin
      out_fold_r <= s2_fold_r;
      out_addr_r <= addr_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_fold_r.kind;
  assign out_ch.address      = out_addr_r;
  assign out_ch.result_value = out_fold_r.result_value;
  assign out_ch.result_index = out_fold_r.result_index;

  // A stalled product stage keeps its word
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !en_s2 |=> s2_v_r)
    else $error("product stage dropped a stalled word");

  // A result word always carries a zero address
  a_result_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_fold_r.kind == KIND_RESULT |-> out_addr_r == '0)
    else $error("result word with nonzero address");

  // The stage feeding the output only advances into a free or draining slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready && s2_v_r |=> out_v_r && s2_v_r)
    else $error("output slot overwritten while stalled");

endmodule

FILE: rtl/strided_tensor_reduction.sv
// Channel  | Dir | Payload                                         | Handshake
// in_ch    | in  | cmd, element_value                              | valid/ready
// out_ch   | out | kind, address, result_value, result_index       | valid/ready
// cfg_*    | in  | cfg_index, cfg_wdata                            | cfg_we, no wait
//
// One input word is taken every cycle while in_ch.ready is high; its word reaches out_ch
// through three registers (fold, product, address sum).
// The fold, odometer step and 64-bit compare/add happen in the accept cycle;
// digit-times-stride products and their sum take one stage each.
// Reset is synchronous on rst_n: control registers return to their defaults, the walk goes idle.
// A stall on out_ch backs up through the stages; in_ch.ready drops only when all are full.
module strided_tensor_reduction
  import strd_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  strd_in_if.sink                in_ch,
  strd_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic [ADDR_W-1:0]      base_r;
  logic [DIM_COUNT_W-1:0] dims_r;
  logic [CFG_DATA_W-1:0]  shape_r;
  logic [CFG_DATA_W-1:0]  stride_r;
  logic [COUNT_W-1:0]     count_r;
  logic [2:0]             mode_r;
  logic [1:0]             etype_r;

  // Walk state
  logic [DIGIT_W-1:0]     digits_r   [MAX_DIMS];
  logic [DIGIT_W-1:0]     digits_nxt [MAX_DIMS];
  logic [DIGIT_W-1:0]     digits_adv [MAX_DIMS];
  logic [COUNT_W-1:0]     seen_r, seen_nxt;
  logic [VALUE_W-1:0]     best_r, best_nxt;
  logic [COUNT_W-1:0]     pos_r, pos_nxt;
  logic [VALUE_W-1:0]     sum_r, sum_nxt;
  logic                   active_r, active_nxt;

  // Fold stage toward the address pipe
  logic                   s1_v_r;
  strd_fold_t             s1_fold_r, fold_nxt;
  logic [DIGIT_W-1:0]     s1_digits_r [MAX_DIMS];
  logic                   s1_en;
  logic                   pipe_ready;

  logic                   in_fire;
  logic                   emit;
  logic                   last_elem;
  logic [DIM_COUNT_W-1:0] dims_used;
  logic [VALUE_W-1:0]     elem_v;
  logic [VALUE_W-1:0]     sum_add;
  logic [COUNT_W-1:0]     limit;
  logic                   is_max;
  logic                   is_min;
  logic                   is_sum;
  logic                   take_best;

  // Clamp the dimension count to 1..MAX_DIMS
  always_comb begin
    if (dims_r == '0) begin
      dims_used = DIM_COUNT_W'(1);
    end else if (int'(dims_r) > MAX_DIMS) begin
      dims_used = DIM_COUNT_W'(MAX_DIMS);
    end else begin
      dims_used = dims_r;
    end
  end

  assign s1_en       = !s1_v_r || pipe_ready;
  assign in_ch.ready = s1_en;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign is_max = (mode_r == MODE_ARGMAX) || (mode_r == MODE_MAX);
  assign is_min = (mode_r == MODE_ARGMIN) || (mode_r == MODE_MIN);
  assign is_sum = mode_r >= MODE_SUM;

  assign elem_v  = sext_elem(in_ch.element_value, etype_r);
  assign sum_add = sum_r + elem_v;
  assign limit   = (count_r == '0) ? COUNT_W'(1) : count_r;

  // First element always wins; later ones only when strictly better
  assign take_best = (seen_r == '0) ||
                     (is_max && ($signed(elem_v) > $signed(best_r))) ||
                     (is_min && ($signed(best_r) > $signed(elem_v)));

  // Odometer step: inner digits wrap at their extent, the outermost never wraps
  always_comb begin
    logic        carry;
    logic [16:0] inc;
    carry = 1'b1;
    inc   = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      digits_adv[d] = digits_r[d];
      if (carry && (d < int'(dims_used))) begin
        inc = {1'b0, digits_r[d]} + 17'd1;
        if ((inc >= {1'b0, shape_r[DIGIT_W*d +: DIGIT_W]}) && (d != int'(dims_used) - 1)) begin
          digits_adv[d] = '0;
        end else begin
          digits_adv[d] = inc[DIGIT_W-1:0];
          carry         = 1'b0;
        end
      end
    end
  end

  // Fold one accepted word into the walk state
  always_comb begin
    digits_nxt = digits_r;
    seen_nxt   = seen_r;
    best_nxt   = best_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    active_nxt = active_r;
    emit       = 1'b0;
    last_elem  = 1'b0;
    fold_nxt   = '{kind: KIND_ADDR, result_value: '0, result_index: '0};
    if (in_fire) begin
      if (in_ch.cmd == CMD_START) begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          digits_nxt[d] = '0;
        end
        seen_nxt   = '0;
        best_nxt   = '0;
        pos_nxt    = '0;
        sum_nxt    = '0;
        active_nxt = 1'b1;
        emit       = 1'b1;
      end else if (active_r) begin
        if (take_best) begin
          best_nxt = elem_v;
          pos_nxt  = seen_r;
        end
        sum_nxt   = sext_elem(sum_add, etype_r);
        seen_nxt  = seen_r + COUNT_W'(1);
        emit      = 1'b1;
        last_elem = seen_nxt >= limit;
        if (last_elem) begin
          active_nxt    = 1'b0;
          fold_nxt.kind = KIND_RESULT;
          if (is_sum) begin
            fold_nxt.result_value = sum_nxt;
          end else begin
            fold_nxt.result_value = best_nxt;
            fold_nxt.result_index = pos_nxt;
          end
        end else begin
          digits_nxt = digits_adv;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      dims_r   <= DIM_COUNT_W'(1);
      shape_r  <= CFG_DATA_W'(1);
      stride_r <= CFG_DATA_W'(1);
      count_r  <= COUNT_W'(1);
      mode_r   <= MODE_ARGMAX;
      etype_r  <= TYPE_INT8;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_BASE_OFFSET:   base_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_DIM_COUNT:     dims_r   <= cfg_wdata[DIM_COUNT_W-1:0];
        CFG_SHAPE:         shape_r  <= cfg_wdata;
        CFG_STRIDE:        stride_r <= cfg_wdata;
        CFG_ELEMENT_COUNT: count_r  <= cfg_wdata[COUNT_W-1:0];
        CFG_REDUCE_MODE:   mode_r   <= cfg_wdata[2:0];
        CFG_ELEMENT_TYPE:  etype_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Walk state and fold stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        digits_r[d] <= '0;
      end
      seen_r   <= '0;
      best_r   <= '0;
      pos_r    <= '0;
      sum_r    <= '0;
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      digits_r <= digits_nxt;
      seen_r   <= seen_nxt;
      best_r   <= best_nxt;
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      active_r <= active_nxt;
      if (s1_en) begin
        s1_v_r <= emit;
      end
    end
  end

  // Hold the fold stage payload until the address pipe takes it
  always_ff @(posedge clk) begin
    if (s1_en && emit) begin
      s1_fold_r   <= fold_nxt;
      s1_digits_r <= digits_nxt;
    end
  end

  strd_addr_pipe #(
    .MAX_DIMS (MAX_DIMS)
  ) u_addr_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (s1_v_r),
    .up_ready      (pipe_ready),
    .up_fold       (s1_fold_r),
    .up_digits     (s1_digits_r),
    .base_offset   (base_r),
    .stride_packed (stride_r),
    .dims_used     (dims_used),
    .out_ch        (out_ch)
  );

  // A start opens a fresh walk at the first element
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.cmd == CMD_START |=> active_r && seen_r == '0)
    else $error("start did not open a fresh walk");

  // The last element closes the walk and queues a result word
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_elem |=> !active_r && s1_v_r && s1_fold_r.kind == KIND_RESULT)
    else $error("last element did not close the walk");

  // Data while idle produces no word and leaves the walk idle
  a_idle_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.cmd == CMD_DATA && !active_r |=> !active_r && !$rose(s1_v_r))
    else $error("data while idle produced a word");

  // Input backpressure only with a full fold stage
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r)
    else $error("input stalled with an empty fold stage");

endmodule
